FILE: hw/rtl/julian_day_to_calendar_date_defines.svh
// Assertion macros shared by the calendar date converter checkers.
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_DEFINES_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define JDCD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define JDCD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define JDCD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/jdcd_pkg.sv
// Package with constants, widths and the day offset table of the calendar date converter.
`timescale 1ns / 1ps
`default_nettype none
package jdcd_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int JD_WIDTH_DEF      = 24;

  localparam int YEAR_WIDTH  = 17;
  localparam int MONTH_WIDTH = 4;
  localparam int DAY_WIDTH   = 5;

  // Pipeline depth from the input register to the output register.
  localparam int PIPE_STAGES = 13;

  // Gregorian correction.
  localparam int GREGORIAN_START = 2299161;
  localparam int ALPHA_BIAS      = 7468865;
  localparam int ALPHA_DIV       = 146097;
  localparam int ALPHA_DIV_WIDTH = 18;
  localparam int ALPHA_REM_WIDTH = 19;

  // Year step: C = (20B - 2442) / 7305.
  localparam int B_OFFSET        = 1524;
  localparam int C_BIAS          = 2442;
  localparam int C_DIV           = 7305;
  localparam int C_DIV_WIDTH     = 13;
  localparam int C_REM_WIDTH     = 14;
  localparam int D_MUL           = 1461;

  // Month step: E = floor((B - D) * 10000 / 306001), done as a rounded-up reciprocal.
  // B - D stays between 123 and 488, so nine bits hold it.
  localparam int DIFF_WIDTH = 9;
  localparam int E_WIDTH    = 4;
  localparam int E_SHIFT    = 28;
  localparam longint unsigned E_MUL =
    ((64'd10000 << E_SHIFT) + 64'd306000) / 64'd306001;
  localparam int E_MUL_WIDTH = 24;

  // Month and year numbering.
  localparam int E_WRAP        = 14;
  localparam int E_LOW_OFFSET  = 1;
  localparam int E_HIGH_OFFSET = 13;
  localparam int MONTH_FEB     = 2;
  localparam int MONTH_JAN     = 1;
  localparam int MONTH_DEC     = 12;
  localparam int DAY_MIN       = 1;
  localparam int DAY_MAX       = 31;
  localparam int YEAR_OFFSET_MAR_DEC = 4716;
  localparam int YEAR_OFFSET_JAN_FEB = 4715;

  // floor(30.6001 * e), the first day offset of each month index.
  function automatic logic [DIFF_WIDTH-1:0] day_offset(input logic [E_WIDTH-1:0] e);
    logic [DIFF_WIDTH-1:0] ofs;
    unique case (e)
      4'd0:  ofs = 9'd0;
      4'd1:  ofs = 9'd30;
      4'd2:  ofs = 9'd61;
      4'd3:  ofs = 9'd91;
      4'd4:  ofs = 9'd122;
      4'd5:  ofs = 9'd153;
      4'd6:  ofs = 9'd183;
      4'd7:  ofs = 9'd214;
      4'd8:  ofs = 9'd244;
      4'd9:  ofs = 9'd275;
      4'd10: ofs = 9'd306;
      4'd11: ofs = 9'd336;
      4'd12: ofs = 9'd367;
      4'd13: ofs = 9'd397;
      4'd14: ofs = 9'd428;
      4'd15: ofs = 9'd459;
    endcase
    return ofs;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/jdcd_ifs.sv
// Valid/ready channel interfaces for Julian Day input and calendar date output.
`timescale 1ns / 1ps
`default_nettype none
interface jdcd_in_if #(
  parameter int FRACTION_BITS = jdcd_pkg::FRACTION_BITS_DEF,
  parameter int JD_WIDTH      = jdcd_pkg::JD_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic [JD_WIDTH-1:0]      jd_whole;
  logic [FRACTION_BITS-1:0] jd_fraction;

  modport source (output valid, jd_whole, jd_fraction, input ready);
  modport sink   (input valid, jd_whole, jd_fraction, output ready);
endinterface

interface jdcd_out_if #(
  parameter int FRACTION_BITS = jdcd_pkg::FRACTION_BITS_DEF
);
  logic                                    valid;
  logic                                    ready;
  logic signed [jdcd_pkg::YEAR_WIDTH-1:0]  year;
  logic [jdcd_pkg::MONTH_WIDTH-1:0]        month;
  logic [jdcd_pkg::DAY_WIDTH-1:0]          day_whole;
  logic [FRACTION_BITS-1:0]                day_fraction;

  modport source (output valid, year, month, day_whole, day_fraction, input ready);
  modport sink   (input valid, year, month, day_whole, day_fraction, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/julian_day_to_calendar_date.sv
// Top level: pipelined Julian Day to calendar date converter.
`timescale 1ns / 1ps
`default_nettype none
// Converts a Julian Day number (whole part plus a binary fraction of a day) into an
// astronomical year, a month, a day of month and the fraction of the civil day. The
// classic algorithm is used: half a day is added, the Gregorian correction applies
// from day 2299161 on, and the 365.25-day and 30.6001-day steps are done with exact
// integer ratios, so results match the integer formulation bit for bit. The block is
// a 13-stage pipeline that takes one transaction per clock cycle unless the output
// stalls, and returns the results in the order accepted. The depth comes from the two
// divisions by constants (by 146097 and by 7305), each of which needs a reciprocal
// multiply, a back-multiply and a one-step correction, followed by the reciprocal
// multiply of the month step. Every stage carries a valid bit; when a result waits
// on the output with ready low, the whole pipeline holds, and input ready drops with
// it. No transaction is dropped or repeated. Reset clears only the valid bits.
module julian_day_to_calendar_date #(
  parameter int FRACTION_BITS = jdcd_pkg::FRACTION_BITS_DEF,
  parameter int JD_WIDTH      = jdcd_pkg::JD_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  jdcd_in_if.sink     jd,
  jdcd_out_if.source  date
);

  localparam int NS   = jdcd_pkg::PIPE_STAGES;
  localparam int ZW   = JD_WIDTH + 1;   // day number after the half-day carry
  localparam int NAW  = ZW + 2;         // 4Z - 7468865
  localparam int NCW  = ZW + 5;         // 20B - 2442
  localparam longint unsigned M_A = (longint'(1) << NAW) / jdcd_pkg::ALPHA_DIV;
  localparam longint unsigned M_C = (longint'(1) << NCW) / jdcd_pkg::C_DIV;
  localparam int MAW  = $clog2(M_A + 1);
  localparam int MCW  = $clog2(M_C + 1);
  localparam int RAW  = jdcd_pkg::ALPHA_REM_WIDTH;
  localparam int RCW  = jdcd_pkg::C_REM_WIDTH;
  localparam int DW   = jdcd_pkg::DIFF_WIDTH;
  localparam int DPW  = DW + 2;
  localparam int EW   = jdcd_pkg::E_WIDTH;
  localparam int EPW  = DW + jdcd_pkg::E_MUL_WIDTH;
  localparam int YW   = jdcd_pkg::YEAR_WIDTH;
  localparam int MW   = jdcd_pkg::MONTH_WIDTH;
  localparam int DAYW = jdcd_pkg::DAY_WIDTH;

  // Pipeline control. The pipeline advances as one when the output register is empty
  // or its result is being taken.
  logic          advance;
  logic [NS-1:0] valid_pipe;

  // The day fraction rides along unchanged after the first stage.
  logic [FRACTION_BITS-1:0] frac_pipe [NS];

  logic [FRACTION_BITS:0] frac_sum;

  // Stage registers.
  logic [ZW-1:0]  z_s1;
  logic           ge_s2, ge_s3, ge_s4, ge_s5;
  logic [ZW-1:0]  z_s2, z_s3, z_s4, z_s5;
  logic [NAW-1:0] na_s2;
  logic [MAW-1:0] qa_s3, qa_s4, alpha_s5;
  logic [RAW-1:0] na_lo_s3, ra_s4;
  logic [ZW-1:0]  b_s6, b_s7, b_s8, b_s9, b_s10;
  logic [NCW-1:0] nc_s7;
  logic [MCW-1:0] qc_s8, qc_s9, c_s10, c_s11, c_s12;
  logic [RCW-1:0] nc_lo_s8, rc_s9;
  logic [DW-1:0]  diff_s11, diff_s12;
  logic [EW-1:0]  e_s12;
  logic [YW-1:0]  year_s13;
  logic [MW-1:0]  month_s13;
  logic [DAYW-1:0] day_s13;

  // Combinational products and results between the registers.
  logic [NAW+MAW-1:0] prod_a;
  logic [MAW+jdcd_pkg::ALPHA_DIV_WIDTH-1:0] back_a;
  logic [NCW+MCW-1:0] prod_c;
  logic [MCW+jdcd_pkg::C_DIV_WIDTH-1:0] back_c;
  logic [DPW-1:0] prod_d;
  logic [EPW-1:0] prod_e;
  logic [MW-1:0]  month_calc;
  logic [YW-1:0]  year_base;
  logic [YW-1:0]  year_calc;

  assign advance  = !valid_pipe[NS-1] || date.ready;
  assign jd.ready = advance;

  // Half a day is added to the fraction; a carry moves the day number up by one.
  assign frac_sum = {1'b0, jd.jd_fraction} + ((FRACTION_BITS + 1)'(1) << (FRACTION_BITS - 1));

  // Reciprocal estimate of (4Z - 7468865) / 146097: low by at most one.
  assign prod_a = {{MAW{1'b0}}, na_s2} * (NAW + MAW)'(M_A);
  // Only the low bits of the remainder matter, since it stays below twice the divisor.
  assign back_a = (MAW + jdcd_pkg::ALPHA_DIV_WIDTH)'(qa_s3) *
                  (MAW + jdcd_pkg::ALPHA_DIV_WIDTH)'(jdcd_pkg::ALPHA_DIV);

  // Same scheme for (20B - 2442) / 7305.
  assign prod_c = {{MCW{1'b0}}, nc_s7} * (NCW + MCW)'(M_C);
  assign back_c = (MCW + jdcd_pkg::C_DIV_WIDTH)'(qc_s8) *
                  (MCW + jdcd_pkg::C_DIV_WIDTH)'(jdcd_pkg::C_DIV);

  // D = 1461C / 4. B - D is below 512, so only the low bits of D are needed.
  assign prod_d = c_s10[DPW-1:0] * DPW'(jdcd_pkg::D_MUL);

  // E = floor((B - D) / 30.6001), exact over the nine-bit range of B - D.
  assign prod_e = EPW'(diff_s11) * EPW'(jdcd_pkg::E_MUL);

  // Month index E runs from 4 to 15; the last two wrap to January and February.
  always_comb begin
    if (e_s12 < EW'(jdcd_pkg::E_WRAP)) begin
      month_calc = MW'(e_s12 - EW'(jdcd_pkg::E_LOW_OFFSET));
    end else begin
      month_calc = MW'(e_s12 - EW'(jdcd_pkg::E_HIGH_OFFSET));
    end
    year_base = YW'({{YW{1'b0}}, c_s12});
    if (month_calc > MW'(jdcd_pkg::MONTH_FEB)) begin
      year_calc = year_base - YW'(jdcd_pkg::YEAR_OFFSET_MAR_DEC);
    end else begin
      year_calc = year_base - YW'(jdcd_pkg::YEAR_OFFSET_JAN_FEB);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (advance) begin
      valid_pipe <= {valid_pipe[NS-2:0], jd.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // Stage 1: half-day add.
      z_s1         <= ZW'(jd.jd_whole) + ZW'(frac_sum[FRACTION_BITS]);
      frac_pipe[0] <= frac_sum[FRACTION_BITS-1:0];
      for (int k = 1; k < NS; k++) begin
        frac_pipe[k] <= frac_pipe[k-1];
      end

      // Stage 2: Gregorian test and numerator of alpha.
      ge_s2 <= z_s1 >= ZW'(jdcd_pkg::GREGORIAN_START);
      na_s2 <= (NAW'(z_s1) << 2) - NAW'(jdcd_pkg::ALPHA_BIAS);
      z_s2  <= z_s1;

      // Stage 3: quotient estimate.
      qa_s3    <= prod_a[NAW +: MAW];
      na_lo_s3 <= na_s2[RAW-1:0];
      ge_s3    <= ge_s2;
      z_s3     <= z_s2;

      // Stage 4: remainder of the estimate.
      ra_s4 <= na_lo_s3 - back_a[RAW-1:0];
      qa_s4 <= qa_s3;
      ge_s4 <= ge_s3;
      z_s4  <= z_s3;

      // Stage 5: correct alpha by one where the remainder reached the divisor.
      alpha_s5 <= qa_s4 + MAW'(ra_s4 >= RAW'(jdcd_pkg::ALPHA_DIV));
      ge_s5    <= ge_s4;
      z_s5     <= z_s4;

      // Stage 6: B = A + 1524, with A corrected on the Gregorian side only.
      if (ge_s5) begin
        b_s6 <= z_s5 + ZW'(1) + ZW'(alpha_s5) - ZW'(alpha_s5 >> 2) +
                ZW'(jdcd_pkg::B_OFFSET);
      end else begin
        b_s6 <= z_s5 + ZW'(jdcd_pkg::B_OFFSET);
      end

      // Stage 7: numerator of C.
      nc_s7 <= (NCW'(b_s6) << 4) + (NCW'(b_s6) << 2) - NCW'(jdcd_pkg::C_BIAS);
      b_s7  <= b_s6;

      // Stage 8: quotient estimate of C.
      qc_s8    <= prod_c[NCW +: MCW];
      nc_lo_s8 <= nc_s7[RCW-1:0];
      b_s8     <= b_s7;

      // Stage 9: remainder of the estimate.
      rc_s9 <= nc_lo_s8 - back_c[RCW-1:0];
      qc_s9 <= qc_s8;
      b_s9  <= b_s8;

      // Stage 10: corrected C.
      c_s10 <= qc_s9 + MCW'(rc_s9 >= RCW'(jdcd_pkg::C_DIV));
      b_s10 <= b_s9;

      // Stage 11: days into the March-based year, B - D.
      diff_s11 <= b_s10[DW-1:0] - prod_d[DPW-1:2];
      c_s11    <= c_s10;

      // Stage 12: month index E.
      e_s12    <= prod_e[jdcd_pkg::E_SHIFT +: EW];
      diff_s12 <= diff_s11;
      c_s12    <= c_s11;

      // Stage 13: output register.
      day_s13   <= DAYW'(diff_s12 - jdcd_pkg::day_offset(e_s12));
      month_s13 <= month_calc;
      year_s13  <= year_calc;
    end
  end

  assign date.valid        = valid_pipe[NS-1];
  assign date.year         = $signed(year_s13);
  assign date.month        = month_s13;
  assign date.day_whole    = day_s13;
  assign date.day_fraction = frac_pipe[NS-1];

endmodule
`default_nettype wire

FILE: hw/rtl/jdcd_checker.sv
// Port-level checker for the calendar date converter and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "julian_day_to_calendar_date_defines.svh"
module jdcd_checker #(
  parameter int FRACTION_BITS = jdcd_pkg::FRACTION_BITS_DEF
) (
  input wire logic                                   clk,
  input wire logic                                   rst,
  input wire logic                                   in_ready,
  input wire logic                                   out_valid,
  input wire logic                                   out_ready,
  input wire logic signed [jdcd_pkg::YEAR_WIDTH-1:0] year,
  input wire logic [jdcd_pkg::MONTH_WIDTH-1:0]       month,
  input wire logic [jdcd_pkg::DAY_WIDTH-1:0]         day_whole,
  input wire logic [FRACTION_BITS-1:0]               day_fraction
);

  localparam int MW = jdcd_pkg::MONTH_WIDTH;
  localparam int DW = jdcd_pkg::DAY_WIDTH;

  // Every result carries a real month and day of month.
  `JDCD_ASSERT_IMPL(a_month_range, clk, rst, out_valid, (month >= MW'(jdcd_pkg::MONTH_JAN)) && (month <= MW'(jdcd_pkg::MONTH_DEC)), "month out of range")
  `JDCD_ASSERT_IMPL(a_day_range, clk, rst, out_valid, (day_whole >= DW'(jdcd_pkg::DAY_MIN)) && (day_whole <= DW'(jdcd_pkg::DAY_MAX)), "day of month out of range")

  // The input side takes a transaction whenever the output side is not stalled.
  `JDCD_ASSERT_IMPL(a_ready_when_free, clk, rst, !out_valid || out_ready, in_ready, "input stalled without an output stall")

  // A result held by back-pressure stays put.
  `JDCD_ASSERT_NEXT(a_hold_stalled, clk, rst, out_valid && !out_ready, out_valid && $stable(year) && $stable(month) && $stable(day_whole) && $stable(day_fraction), "stalled result changed")

  // Reset empties the pipeline.
  `JDCD_ASSERT_NEXT_ALWAYS(a_reset_empties, clk, rst, !out_valid, "result valid after reset")

endmodule

bind julian_day_to_calendar_date jdcd_checker #(
  .FRACTION_BITS(FRACTION_BITS)
) u_jdcd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (jd.ready),
  .out_valid    (date.valid),
  .out_ready    (date.ready),
  .year         (date.year),
  .month        (date.month),
  .day_whole    (date.day_whole),
  .day_fraction (date.day_fraction)
);
`default_nettype wire

FILE: verif/julian_day_to_calendar_date_tb.sv
// Self-checking testbench for the Julian Day to calendar date converter.
`timescale 1ns / 1ps
module julian_day_to_calendar_date_tb;

  // Widths of the channels, taken from the package so that the payloads line up with the
  // ports. The calendar arithmetic below keeps its own constants.
  localparam int FRAC_W  = jdcd_pkg::FRACTION_BITS_DEF;
  localparam int JD_W    = jdcd_pkg::JD_WIDTH_DEF;
  localparam int YEAR_W  = jdcd_pkg::YEAR_WIDTH;
  localparam int MONTH_W = jdcd_pkg::MONTH_WIDTH;
  localparam int DAY_W   = jdcd_pkg::DAY_WIDTH;

  // Length of the quiet stretch at the end of the run, taken from the pipeline depth.
  localparam int DRAIN_CYCLES = jdcd_pkg::PIPE_STAGES + 4;

  // The run stops with a failure if no transaction moves on either channel for this many
  // cycles. The slowest correct run has its longest quiet stretch during the output
  // hold-off, which is far shorter.
  localparam int WATCHDOG_LIMIT = 3000;

  // The output side holds off once, for this many cycles, after this many input
  // transactions, so that the pipeline fills and input ready drops.
  localparam int HOLD_TRIGGER = 60;
  localparam int HOLD_CYCLES  = 150;

  localparam int RANDOM_ITEMS = 850;
  localparam int PHASE_COUNT  = 4;

  // Calendar constants: start of the Gregorian calendar, the exact rationals that replace
  // 1867216.25 / 36524.25, 122.1 / 365.25 and 30.6001, and the year offsets.
  localparam longint GREG_FIRST_DAY = 2299161;
  localparam longint CENT_BIAS      = 7468865;
  localparam longint CENT_DAYS_X4   = 146097;
  localparam longint EPOCH_SHIFT    = 1524;
  localparam longint YEAR_BIAS      = 2442;
  localparam longint YEAR_DAYS_X20  = 7305;
  localparam longint QUAD_YEAR_DAYS = 1461;
  localparam longint MONTH_NUM      = 10000;
  localparam longint MONTH_DEN      = 306001;
  localparam longint MONTH_WRAP     = 14;
  localparam longint FEBRUARY       = 2;
  localparam longint YEAR_OFS_LATE  = 4716;
  localparam longint YEAR_OFS_EARLY = 4715;

  // One expected date, with the Julian Day that caused it kept for the error messages.
  typedef struct packed {
    logic [JD_W-1:0]          jd_whole;
    logic [FRAC_W-1:0]        jd_fraction;
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day_whole;
    logic [FRAC_W-1:0]        day_fraction;
  } civil_date_t;

  // The scoreboard turns every accepted Julian Day into its calendar date and compares the
  // dates that come out of the block, in order, against those predictions.
  class date_scoreboard;
    civil_date_t pending_dates[$];
    int          mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Meeus' conversion with every floating-point step replaced by integer division.
    // All intermediate values are non-negative, so truncating division is the floor.
    function civil_date_t calendar_of(logic [JD_W-1:0] whole, logic [FRAC_W-1:0] frac);
      civil_date_t r;
      longint      shifted, z, a, b, c, d, e, alpha, mon, yr, dom;
      // Moving the day start from noon to midnight: a carry out of the fraction bumps the
      // day number, and the remainder is the civil fraction of the day.
      shifted = longint'(frac) + (longint'(1) << (FRAC_W - 1));
      z       = longint'(whole) + (shifted >> FRAC_W);
      if (z < GREG_FIRST_DAY) begin
        a = z;
      end else begin
        alpha = (4 * z - CENT_BIAS) / CENT_DAYS_X4;
        a     = z + 1 + alpha - alpha / 4;
      end
      b   = a + EPOCH_SHIFT;
      c   = (20 * b - YEAR_BIAS) / YEAR_DAYS_X20;
      d   = (QUAD_YEAR_DAYS * c) / 4;
      e   = (MONTH_NUM * (b - d)) / MONTH_DEN;
      dom = b - d - (MONTH_DEN * e) / MONTH_NUM;
      mon = (e < MONTH_WRAP) ? e - 1 : e - 13;
      yr  = (mon > FEBRUARY) ? c - YEAR_OFS_LATE : c - YEAR_OFS_EARLY;
      r.jd_whole     = whole;
      r.jd_fraction  = frac;
      r.year         = yr[YEAR_W-1:0];
      r.month        = mon[MONTH_W-1:0];
      r.day_whole    = dom[DAY_W-1:0];
      r.day_fraction = shifted[FRAC_W-1:0];
      return r;
    endfunction

    function void note_jd(logic [JD_W-1:0] whole, logic [FRAC_W-1:0] frac);
      pending_dates.push_back(calendar_of(whole, frac));
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_date(logic signed [YEAR_W-1:0] year, logic [MONTH_W-1:0] month,
                    logic [DAY_W-1:0] day_whole, logic [FRAC_W-1:0] day_fraction);
      civil_date_t want;
      if (pending_dates.size() == 0) begin
        report_mismatch($sformatf("date %0d-%0d-%0d frac %h with no Julian Day pending",
                                  year, month, day_whole, day_fraction));
        return;
      end
      want = pending_dates.pop_front();
      if (year !== want.year)
        report_mismatch($sformatf("JD %0d frac %h: year %0d, expected %0d",
                                  want.jd_whole, want.jd_fraction, year, want.year));
      if (month !== want.month)
        report_mismatch($sformatf("JD %0d frac %h: month %0d, expected %0d",
                                  want.jd_whole, want.jd_fraction, month, want.month));
      if (day_whole !== want.day_whole)
        report_mismatch($sformatf("JD %0d frac %h: day %0d, expected %0d",
                                  want.jd_whole, want.jd_fraction, day_whole,
                                  want.day_whole));
      if (day_fraction !== want.day_fraction)
        report_mismatch($sformatf("JD %0d frac %h: day fraction %h, expected %h",
                                  want.jd_whole, want.jd_fraction, day_fraction,
                                  want.day_fraction));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  jdcd_in_if  #(.FRACTION_BITS(FRAC_W), .JD_WIDTH(JD_W)) jd_ch ();
  jdcd_out_if #(.FRACTION_BITS(FRAC_W))                  date_ch ();

  julian_day_to_calendar_date #(
    .FRACTION_BITS(FRAC_W),
    .JD_WIDTH     (JD_W)
  ) dut (
    .clk (clk),
    .rst (rst),
    .jd  (jd_ch),
    .date(date_ch)
  );

  // 10 ns clock period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  date_scoreboard sb;

  // Idle and stall rates of the current phase, in percent of cycles.
  int src_idle_pct;
  int sink_stall_pct;

  int inputs_accepted;
  int quiet_cycles;
  bit held_off;

  // Monitor. It samples both channels at the rising edge, before any of the nonblocking
  // updates of that edge land, so a transaction is seen exactly when valid and ready were
  // both high going into the edge. The input transaction is noted first, so that even a
  // combinational pass-through would find its prediction waiting.
  always @(posedge clk) begin
    if (rst) begin
      inputs_accepted <= 0;
      quiet_cycles    <= 0;
    end else begin
      if (jd_ch.valid && jd_ch.ready) begin
        sb.note_jd(jd_ch.jd_whole, jd_ch.jd_fraction);
        inputs_accepted <= inputs_accepted + 1;
      end
      if (date_ch.valid && date_ch.ready)
        sb.check_date(date_ch.year, date_ch.month, date_ch.day_whole, date_ch.day_fraction);
      if ((jd_ch.valid && jd_ch.ready) || (date_ch.valid && date_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog. A run that stops moving transactions ends here as a failure.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Output side. It stalls at the rate of the current phase. Once, early in the first phase
  // without idling, it holds ready low for a long stretch while the sender keeps offering
  // Julian Days, so the pipeline fills up and must back-pressure its input.
  initial begin
    date_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && inputs_accepted >= HOLD_TRIGGER) begin
        held_off = 1'b1;
        date_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        date_ch.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
        @(posedge clk);
      end
    end
  end

  // Offers one Julian Day and returns at the edge where it is accepted. Idle cycles are
  // inserted before the offer at the rate of the current phase. Valid is not lowered after
  // acceptance here: the next call either raises it again with new data or drops it for an
  // idle cycle, so valid gets only one assignment per edge.
  task automatic offer_jd(input logic [JD_W-1:0] whole, input logic [FRAC_W-1:0] frac);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      jd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    jd_ch.valid       <= 1'b1;
    jd_ch.jd_whole    <= whole;
    jd_ch.jd_fraction <= frac;
    @(posedge clk);
    while (!jd_ch.ready) @(posedge clk);
  endtask

  // Random day numbers. Besides the full range, they cluster where the arithmetic has
  // edges: the calendar reform, the starts of Gregorian centuries, both ends of the range,
  // the Julian era and the present era, where most real timestamps live.
  function automatic logic [JD_W-1:0] pick_jd();
    int k;
    case ($urandom_range(7, 0))
      0, 1: pick_jd = JD_W'($urandom_range(24'hFFFFFF, 0));
      2:    pick_jd = JD_W'(GREG_FIRST_DAY - 200 + $urandom_range(400, 0));
      3:    pick_jd = JD_W'(2415000 + $urandom_range(80000, 0));
      4: begin
        k = $urandom_range(400, 0);
        pick_jd = JD_W'(1721060 + 36524 * k + $urandom_range(800, 0) - 400);
      end
      5:    pick_jd = JD_W'($urandom_range(2000, 0));
      6:    pick_jd = JD_W'(24'hFFFFFF - $urandom_range(2000, 0));
      default: pick_jd = JD_W'($urandom_range(32'(GREG_FIRST_DAY - 1), 0));
    endcase
  endfunction

  // Fractions are mostly uniform, with extra weight around the half-day carry and at the
  // two ends of the field.
  function automatic logic [FRAC_W-1:0] pick_fraction();
    case ($urandom_range(5, 0))
      0:       pick_fraction = FRAC_W'(16'h7FFE + $urandom_range(3, 0));
      1:       pick_fraction = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
      default: pick_fraction = FRAC_W'($urandom_range(16'hFFFF, 0));
    endcase
  endfunction

  // Stimulus: reset, a directed list, then four phases of random Julian Days with
  // different idle and stall rates, then the drain and the verdict.
  initial begin
    int src_rates  [PHASE_COUNT];
    int sink_rates [PHASE_COUNT];
    src_rates  = '{0, 70, 0, 6};
    sink_rates = '{0, 0, 70, 6};
    sb = new();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    held_off       = 1'b0;
    rst               <= 1'b1;
    jd_ch.valid       <= 1'b0;
    jd_ch.jd_whole    <= '0;
    jd_ch.jd_fraction <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Both ends of the fraction, with and without the half-day carry at day zero.
    offer_jd(24'd0, 16'h0000);
    offer_jd(24'd0, 16'h7FFF);
    offer_jd(24'd0, 16'h8000);
    offer_jd(24'd0, 16'hFFFF);
    offer_jd(24'd1, 16'hC000);
    // The largest day number: the carry pushes the day past the width of the input field.
    offer_jd(24'hFFFFFF, 16'h0000);
    offer_jd(24'hFFFFFF, 16'hFFFF);
    // Around the calendar reform, reached both directly and through the carry.
    offer_jd(24'd2299159, 16'h8000);
    offer_jd(24'd2299160, 16'h0000);
    offer_jd(24'd2299160, 16'h8000);
    offer_jd(24'd2299161, 16'h0000);
    // Year zero and the turn of the year into January, where the year offset changes.
    offer_jd(24'd1721057, 16'h8000);
    offer_jd(24'd1721423, 16'h8000);
    // A century year that is not a leap year, and one that is.
    offer_jd(24'd2415078, 16'h8000);
    offer_jd(24'd2415079, 16'h8000);
    offer_jd(24'd2451544, 16'h8000);
    offer_jd(24'd2451603, 16'h8000);
    offer_jd(24'd2451909, 16'h8000);
    // Alternating bit patterns in both fields.
    offer_jd(24'hAAAAAA, 16'h5555);
    offer_jd(24'h555555, 16'hAAAA);
    offer_jd(24'd2460000, 16'h0001);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      src_idle_pct   = src_rates[phase];
      sink_stall_pct = sink_rates[phase];
      repeat (RANDOM_ITEMS / PHASE_COUNT) offer_jd(pick_jd(), pick_fraction());
    end
    jd_ch.valid <= 1'b0;

    // Wait for every predicted date, then a little longer to catch any extra result.
    while (sb.pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_dates.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
